// ===== sv/misaligned_word_memory_compare_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef MISALIGNED_WORD_MEMORY_COMPARE_TOP_MACROS_SVH
`define MISALIGNED_WORD_MEMORY_COMPARE_TOP_MACROS_SVH

// Assertion that is switched off while reset is held.
`define MWMC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that is also checked around reset.
`define MWMC_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/mwmc_pkg.sv =====
`timescale 1ns / 1ps

package mwmc_pkg;

    // Fixed widths of the word fields.
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int LANES       = 4;
    localparam int OFF_W       = 2;
    localparam int LEN_FIELD_W = 16;
    localparam int DIFF_W      = 9;

    // Byte offset codes within an aligned word.
    typedef enum logic [OFF_W-1:0] {
        OFF_0 = 2'd0,
        OFF_1 = 2'd1,
        OFF_2 = 2'd2,
        OFF_3 = 2'd3
    } offset_t;

    // What one byte lane reports to the merge stage.
    typedef struct packed {
        logic              hit;
        logic [DIFF_W-1:0] diff;
    } lane_result_t;

endpackage

// ===== sv/mwmc_align.sv =====
`timescale 1ns / 1ps

module mwmc_align
    import mwmc_pkg::*;
(
    input  logic [WORD_W-1:0] prev_word,
    input  logic [WORD_W-1:0] cur_word,
    input  logic [OFF_W-1:0]  offset,
    output logic [WORD_W-1:0] aligned_word
);

    // Funnel shift across the previous and current word; an aligned stream uses
    // the previous word as it is.
    always_comb begin
        unique case (offset_t'(offset))
            OFF_0:   aligned_word = prev_word;
            OFF_1:   aligned_word = {cur_word[BYTE_W-1:0], prev_word[WORD_W-1:BYTE_W]};
            OFF_2:   aligned_word = {cur_word[2*BYTE_W-1:0], prev_word[WORD_W-1:2*BYTE_W]};
            OFF_3:   aligned_word = {cur_word[3*BYTE_W-1:0], prev_word[WORD_W-1:3*BYTE_W]};
            default: aligned_word = prev_word;
        endcase
    end

endmodule

// ===== sv/mwmc_lane.sv =====
`timescale 1ns / 1ps

module mwmc_lane
    import mwmc_pkg::*;
(
    input  logic [BYTE_W-1:0] byte_a,
    input  logic [BYTE_W-1:0] byte_b,
    input  logic              enable,
    output lane_result_t      result
);

    // A lane reports a hit only when its byte still counts and the bytes differ.
    always_comb begin
        result.hit  = enable && (byte_a != byte_b);
        result.diff = {1'b0, byte_a} - {1'b0, byte_b};
    end

endmodule

// ===== sv/mwmc_merge.sv =====
`timescale 1ns / 1ps

module mwmc_merge
    import mwmc_pkg::*;
(
    input  lane_result_t [LANES-1:0] lane_results,
    output logic                     found,
    output logic [DIFF_W-1:0]        diff
);

    // The lowest lane in memory order that differs wins.
    always_comb begin
        found = 1'b0;
        diff  = '0;
        for (int k = LANES - 1; k >= 0; k--) begin
            if (lane_results[k].hit) begin
                found = 1'b1;
                diff  = lane_results[k].diff;
            end
        end
    end

endmodule

// ===== sv/misaligned_word_memory_compare_top.sv =====
`timescale 1ns / 1ps
// The deciding word's result goes to the output register, or to the skid entry.
// One word per cycle while s_ready is high; four byte lanes check each word pair.
// A two-entry output buffer keeps s_ready high while one result waits to be taken.
// Reset (aresetn low, synchronous) leaves the block idle with no result pending.

module misaligned_word_memory_compare_top
    import mwmc_pkg::*;
#(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_first,
    input  logic [OFF_W-1:0]        s_offset_a,
    input  logic [OFF_W-1:0]        s_offset_b,
    input  logic [LEN_FIELD_W-1:0]  s_length,
    input  logic [WORD_W-1:0]       s_word_a,
    input  logic [WORD_W-1:0]       s_word_b,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [DIFF_W-1:0] m_difference
);

    logic [WORD_W-1:0]       prev_a_reg, prev_a_next;
    logic [WORD_W-1:0]       prev_b_reg, prev_b_next;
    logic [LENGTH_WIDTH-1:0] remaining_reg, remaining_next;
    logic [OFF_W-1:0]        off_a_reg, off_a_next;
    logic [OFF_W-1:0]        off_b_reg, off_b_next;
    logic                    comparing_reg, comparing_next;

    logic                    out_valid_reg;
    logic [DIFF_W-1:0]       out_diff_reg;
    logic                    skid_valid_reg;
    logic [DIFF_W-1:0]       skid_diff_reg;

    logic [LEN_FIELD_W+LENGTH_WIDTH-1:0] length_ext;
    logic [LENGTH_WIDTH-1:0] length_in;
    logic                    accept;
    logic [WORD_W-1:0]       aligned_a;
    logic [WORD_W-1:0]       aligned_b;
    lane_result_t [LANES-1:0] lane_results;
    logic                    found;
    logic [DIFF_W-1:0]       found_diff;
    logic                    last_word;
    logic                    res_valid;
    logic [DIFF_W-1:0]       res_diff;

    // The length is taken modulo the counter width.
    assign length_ext = {{LENGTH_WIDTH{1'b0}}, s_length};
    assign length_in  = length_ext[LENGTH_WIDTH-1:0];

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    // Rebuild one compare word per stream.
    mwmc_align u_align_a (
        .prev_word    (prev_a_reg),
        .cur_word     (s_word_a),
        .offset       (off_a_reg),
        .aligned_word (aligned_a)
    );

    mwmc_align u_align_b (
        .prev_word    (prev_b_reg),
        .cur_word     (s_word_b),
        .offset       (off_b_reg),
        .aligned_word (aligned_b)
    );

    // One lane per byte; a lane counts only while bytes remain for it.
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        mwmc_lane u_lane (
            .byte_a (aligned_a[k*BYTE_W +: BYTE_W]),
            .byte_b (aligned_b[k*BYTE_W +: BYTE_W]),
            .enable (remaining_reg > LENGTH_WIDTH'(k)),
            .result (lane_results[k])
        );
    end

    mwmc_merge u_merge (
        .lane_results (lane_results),
        .found        (found),
        .diff         (found_diff)
    );

    assign last_word = remaining_reg <= LENGTH_WIDTH'(LANES);

    // Comparison state and the result of the word in hand.
    always_comb begin
        prev_a_next    = prev_a_reg;
        prev_b_next    = prev_b_reg;
        remaining_next = remaining_reg;
        off_a_next     = off_a_reg;
        off_b_next     = off_b_reg;
        comparing_next = comparing_reg;
        res_valid      = 1'b0;
        res_diff       = '0;
        if (accept && s_first) begin
            if (length_in == '0) begin
                comparing_next = 1'b0;
                remaining_next = '0;
                res_valid      = 1'b1;
            end else begin
                prev_a_next    = s_word_a;
                prev_b_next    = s_word_b;
                off_a_next     = s_offset_a;
                off_b_next     = s_offset_b;
                remaining_next = length_in;
                comparing_next = 1'b1;
            end
        end else if (accept && comparing_reg) begin
            prev_a_next = s_word_a;
            prev_b_next = s_word_b;
            if (found) begin
                comparing_next = 1'b0;
                remaining_next = '0;
                res_valid      = 1'b1;
                res_diff       = found_diff;
            end else if (last_word) begin
                comparing_next = 1'b0;
                remaining_next = '0;
                res_valid      = 1'b1;
            end else begin
                remaining_next = remaining_reg - LENGTH_WIDTH'(LANES);
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_a_reg    <= '0;
            prev_b_reg    <= '0;
            remaining_reg <= '0;
            off_a_reg     <= '0;
            off_b_reg     <= '0;
            comparing_reg <= 1'b0;
        end else begin
            prev_a_reg    <= prev_a_next;
            prev_b_reg    <= prev_b_next;
            remaining_reg <= remaining_next;
            off_a_reg     <= off_a_next;
            off_b_reg     <= off_b_next;
            comparing_reg <= comparing_next;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_diff_reg   <= skid_diff_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= res_valid;
                out_diff_reg  <= res_diff;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
            skid_diff_reg  <= res_diff;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_difference = out_diff_reg;

endmodule

// ===== sv/mwmc_checker.sv =====
`timescale 1ns / 1ps
`include "misaligned_word_memory_compare_top_macros.svh"

module mwmc_checker
    import mwmc_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     s_first,
    input logic [LEN_FIELD_W-1:0]   s_length,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [DIFF_W-1:0] m_difference
);

    // A stalled result word holds its value.
    `MWMC_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready |=> m_valid && $stable(m_difference)), "stalled result changed")

    // A byte difference never reaches -256.
    `MWMC_ASSERT(a_diff_range, aclk, aresetn, (m_valid |-> m_difference != 9'h100), "difference out of range")

    // A zero-length start with an empty output gives a zero result next cycle.
    `MWMC_ASSERT(a_zero_len, aclk, aresetn, (s_valid && s_ready && s_first && s_length == '0 && !m_valid |=> m_valid && m_difference == '0), "zero length gave no zero result")

    // The input side stalls only while a result is waiting.
    `MWMC_ASSERT(a_stall_cause, aclk, aresetn, (!s_ready |-> m_valid), "input stalled with no result pending")

    // Reset clears the result side.
    `MWMC_ASSERT_NR(a_reset_idle, aclk, (!aresetn |=> !m_valid), "result valid after reset")

endmodule

bind misaligned_word_memory_compare_top mwmc_checker u_mwmc_checker (.*);
